### src/rvie_pkg.sv
// ----------------------------------------------------------------------------
// rvie_pkg
// shared types and encodings for the rv32i i-format execute pipeline
// ----------------------------------------------------------------------------
package rvie_pkg;

  localparam int XLEN = 32;

  // instruction class selector
  typedef enum logic [1:0] {
    KIND_ALU  = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_JALR = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  // funct3 codes for the immediate alu group
  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_SLLI  = 3'd1;
  localparam logic [2:0] F3_SLTI  = 3'd2;
  localparam logic [2:0] F3_SLTIU = 3'd3;
  localparam logic [2:0] F3_XORI  = 3'd4;
  localparam logic [2:0] F3_SRXI  = 3'd5;
  localparam logic [2:0] F3_ORI   = 3'd6;
  localparam logic [2:0] F3_ANDI  = 3'd7;

  // funct3 codes for loads
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [XLEN-1:0] LINK_STEP = 32'd4;

  // decoded fields handed from the decoder to the pipeline
  typedef struct packed {
    kind_t            kind;
    logic [2:0]       f3;
    logic [4:0]       rd_index;
    logic [XLEN-1:0]  imm;
    logic [4:0]       shamt;
    logic             arith;
    logic             illegal;
    logic [1:0]       size;
  } dec_t;

endpackage

### src/rvie_if.sv
// ----------------------------------------------------------------------------
// rvie channel interfaces
// valid/ready channels carrying the instruction word and the result word
// ----------------------------------------------------------------------------
interface rvie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] instr_word;
  logic [31:0] rs1_value;
  logic [31:0] pc_value;
  logic [31:0] mem_data;

  modport source (output valid, opcode, instr_word, rs1_value, pc_value, mem_data,
                  input ready);
  modport sink (input valid, opcode, instr_word, rs1_value, pc_value, mem_data,
                output ready);
endinterface

interface rvie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rd_value;
  logic [4:0]  rd_index;
  logic        rd_write;
  logic [31:0] mem_address;
  logic [1:0]  mem_size;
  logic [31:0] next_pc;
  logic        pc_redirect;
  logic        illegal;

  modport source (output valid, rd_value, rd_index, rd_write, mem_address, mem_size,
                  next_pc, pc_redirect, illegal, input ready);
  modport sink (input valid, rd_value, rd_index, rd_write, mem_address, mem_size,
                next_pc, pc_redirect, illegal, output ready);
endinterface

### src/rvie_decode.sv
// ----------------------------------------------------------------------------
// rvie_decode
// splits the i-format word into fields and flags bad encodings
// ----------------------------------------------------------------------------
module rvie_decode import rvie_pkg::*; (
  input  logic [1:0]  opcode,
  input  logic [31:0] instr_word,
  output dec_t        dec
);

  logic [2:0] f3;
  logic       bad;

  assign f3 = instr_word[14:12];

  always_comb begin
    bad = 1'b0;
    unique case (kind_t'(opcode))
      KIND_ALU:  bad = (f3 == F3_SRXI) && instr_word[31];
      KIND_LOAD: bad = !((f3 == F3_LB) || (f3 == F3_LH) || (f3 == F3_LW) ||
                         (f3 == F3_LBU) || (f3 == F3_LHU));
      KIND_JALR: bad = 1'b0;
      default:   bad = 1'b1;
    endcase
  end

  always_comb begin
    dec.kind     = kind_t'(opcode);
    dec.f3       = f3;
    dec.rd_index = instr_word[11:7];
    dec.imm      = {{20{instr_word[31]}}, instr_word[31:20]};
    dec.shamt    = instr_word[24:20];
    dec.arith    = instr_word[30];
    dec.illegal  = bad;
    // lb/lbu byte, lh/lhu half, lw word
    dec.size     = f3[1:0];
  end

endmodule

### src/rv32i_itype_execute.sv
// ----------------------------------------------------------------------------
// rv32i_itype_execute
// three-stage execute pipeline for rv32i i-format instructions
// ----------------------------------------------------------------------------
// path: a taken input word passes the stage 1, stage 2 and output registers in turn
// throughput: one word per cycle while out_chan.ready holds, set by the single result per stage
// stalls: each stage holds while the next one is full and not draining
// reset: synchronous active-low rst_n clears the stage valid bits only
// ----------------------------------------------------------------------------
module rv32i_itype_execute import rvie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rvie_in_if.sink    in_chan,
  rvie_out_if.source out_chan
);

  // stage advance enables, chained back from the output register
  logic adv1, adv2, adv3;

  // stage 1: decoded fields and operands
  logic            v1_r;
  dec_t            dec1_r;
  logic [XLEN-1:0] rs1_1_r, pc_1_r, mdata_1_r;
  dec_t            dec_nxt;

  // stage 2: raw results
  logic            v2_r;
  dec_t            dec2_r;
  logic [XLEN-1:0] res2_r, sum2_r;
  logic [XLEN-1:0] res2_nxt, sum2_nxt;

  // stage 3: output register
  logic            v3_r;
  logic [XLEN-1:0] rd_value_r, mem_address_r, next_pc_r;
  logic [4:0]      rd_index_r;
  logic [1:0]      mem_size_r;
  logic            redirect_r, illegal_r;

  assign adv3 = !v3_r || out_chan.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_chan.ready = adv1;

  // ---- stage 1: decode ----
  rvie_decode u_decode (
    .opcode     (in_chan.opcode),
    .instr_word (in_chan.instr_word),
    .dec        (dec_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      dec1_r    <= dec_nxt;
      rs1_1_r   <= in_chan.rs1_value;
      pc_1_r    <= in_chan.pc_value;
      mdata_1_r <= in_chan.mem_data;
    end
  end

  // ---- stage 2: adder, compares, shifter, logic ops, load extension ----
  logic [XLEN-1:0] alu_res, load_res;
  logic            ext_bit;

  assign sum2_nxt = rs1_1_r + dec1_r.imm;

  always_comb begin
    unique case (dec1_r.f3)
      F3_ADDI:  alu_res = sum2_nxt;
      F3_SLLI:  alu_res = rs1_1_r << dec1_r.shamt;
      F3_SLTI:  alu_res = {31'd0, $signed(rs1_1_r) < $signed(dec1_r.imm)};
      F3_SLTIU: alu_res = {31'd0, rs1_1_r < dec1_r.imm};
      F3_XORI:  alu_res = rs1_1_r ^ dec1_r.imm;
      F3_SRXI:  alu_res = dec1_r.arith ? XLEN'($signed(rs1_1_r) >>> dec1_r.shamt)
                                       : (rs1_1_r >> dec1_r.shamt);
      F3_ORI:   alu_res = rs1_1_r | dec1_r.imm;
      F3_ANDI:  alu_res = rs1_1_r & dec1_r.imm;
      default:  alu_res = '0;
    endcase
  end

  // funct3 bit 2 marks the zero-extending loads
  always_comb begin
    ext_bit  = 1'b0;
    load_res = mdata_1_r;
    unique case (dec1_r.size)
      SIZE_BYTE: begin
        ext_bit  = mdata_1_r[7] && !dec1_r.f3[2];
        load_res = {{24{ext_bit}}, mdata_1_r[7:0]};
      end
      SIZE_HALF: begin
        ext_bit  = mdata_1_r[15] && !dec1_r.f3[2];
        load_res = {{16{ext_bit}}, mdata_1_r[15:0]};
      end
      default: begin
        ext_bit  = 1'b0;
        load_res = mdata_1_r;
      end
    endcase
  end

  always_comb begin
    unique case (dec1_r.kind)
      KIND_ALU:  res2_nxt = alu_res;
      KIND_LOAD: res2_nxt = load_res;
      KIND_JALR: res2_nxt = pc_1_r + LINK_STEP;
      default:   res2_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      dec2_r <= dec1_r;
      res2_r <= res2_nxt;
      sum2_r <= sum2_nxt;
    end
  end

  // ---- stage 3: field selection and zeroing of unused outputs ----
  logic is_load, is_jalr;

  assign is_load = (dec2_r.kind == KIND_LOAD) && !dec2_r.illegal;
  assign is_jalr = (dec2_r.kind == KIND_JALR) && !dec2_r.illegal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      rd_value_r    <= dec2_r.illegal ? '0 : res2_r;
      rd_index_r    <= dec2_r.rd_index;
      mem_address_r <= is_load ? sum2_r : '0;
      mem_size_r    <= is_load ? dec2_r.size : SIZE_BYTE;
      // target drops bit 0
      next_pc_r     <= is_jalr ? {sum2_r[XLEN-1:1], 1'b0} : '0;
      redirect_r    <= is_jalr;
      illegal_r     <= dec2_r.illegal;
    end
  end

  assign out_chan.valid       = v3_r;
  assign out_chan.rd_value    = rd_value_r;
  assign out_chan.rd_index    = rd_index_r;
  assign out_chan.rd_write    = !illegal_r;
  assign out_chan.mem_address = mem_address_r;
  assign out_chan.mem_size    = mem_size_r;
  assign out_chan.next_pc     = next_pc_r;
  assign out_chan.pc_redirect = redirect_r;
  assign out_chan.illegal     = illegal_r;

  // ---- checks ----
  // a full output stage that is not taken stays full
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_chan.ready |=> v3_r)
    else $error("output word dropped while stalled");

  // a word in stage 2 blocked by stage 3 is not lost
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !adv3 |=> v2_r && $stable(res2_r))
    else $error("stage 2 word lost during stall");

  // illegal words carry no register write, redirect or load access
  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && illegal_r |-> rd_value_r == '0 && !redirect_r && mem_address_r == '0)
    else $error("illegal word produced side effects");

  // a redirect target is always halfword aligned
  a_target_align: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && redirect_r |-> !next_pc_r[0] && !illegal_r)
    else $error("misaligned jump target");

endmodule

### tb/rvie_tb_pkg.sv
// ----------------------------------------------------------------------------
// rvie_tb_pkg
// encodings shared by the execute unit stimulus and its checker
// ----------------------------------------------------------------------------
package rvie_tb_pkg;

  // instr[31:30] selector for the right shift group
  localparam logic [1:0] SHIFT_LOGICAL = 2'b00;
  localparam logic [1:0] SHIFT_ARITH   = 2'b01;
  localparam logic [1:0] SHIFT_RSVD_LO = 2'b10;
  localparam logic [1:0] SHIFT_RSVD_HI = 2'b11;

endpackage

### tb/rv32i_itype_execute_checker.sv
// ----------------------------------------------------------------------------
// rv32i_itype_execute_checker
// watches both channels, works out the result of every accepted instruction
// word and compares it field by field with the words that come out
// ----------------------------------------------------------------------------
module rv32i_itype_execute_checker import rvie_pkg::*; import rvie_tb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rvie_in_if   in_mon,
  rvie_out_if  out_mon,
  output int   mismatches,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    logic [31:0] rd_value;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [31:0] next_pc;
    logic        pc_redirect;
    logic        illegal;
  } exec_result_t;

  exec_result_t expected_q[$];

  function automatic exec_result_t execute_itype(kind_t kind, logic [31:0] insn,
                                                 logic [31:0] rs1, logic [31:0] pc,
                                                 logic [31:0] mdata);
    exec_result_t r;
    logic [31:0]  imm;
    logic [2:0]   f3;
    logic [4:0]   shamt;
    logic         bad;
    r     = '0;
    bad   = 1'b0;
    imm   = {{20{insn[31]}}, insn[31:20]};
    f3    = insn[14:12];
    shamt = insn[24:20];
    case (kind)
      KIND_ALU: begin
        case (f3)
          F3_ADDI:  r.rd_value = rs1 + imm;
          F3_SLLI:  r.rd_value = rs1 << shamt;
          F3_SLTI:  r.rd_value = {31'd0, $signed(rs1) < $signed(imm)};
          F3_SLTIU: r.rd_value = {31'd0, rs1 < imm};
          F3_XORI:  r.rd_value = rs1 ^ imm;
          F3_SRXI: begin
            case (insn[31:30])
              SHIFT_LOGICAL: r.rd_value = rs1 >> shamt;
              SHIFT_ARITH:   r.rd_value = $signed(rs1) >>> shamt;
              default:       bad = 1'b1;
            endcase
          end
          F3_ORI:   r.rd_value = rs1 | imm;
          default:  r.rd_value = rs1 & imm;
        endcase
      end
      KIND_LOAD: begin
        r.mem_address = rs1 + imm;
        case (f3)
          F3_LB: begin
            r.mem_size = SIZE_BYTE;
            r.rd_value = {{24{mdata[7]}}, mdata[7:0]};
          end
          F3_LH: begin
            r.mem_size = SIZE_HALF;
            r.rd_value = {{16{mdata[15]}}, mdata[15:0]};
          end
          F3_LW: begin
            r.mem_size = SIZE_WORD;
            r.rd_value = mdata;
          end
          F3_LBU: begin
            r.mem_size = SIZE_BYTE;
            r.rd_value = {24'd0, mdata[7:0]};
          end
          F3_LHU: begin
            r.mem_size = SIZE_HALF;
            r.rd_value = {16'd0, mdata[15:0]};
          end
          default: bad = 1'b1;
        endcase
      end
      KIND_JALR: begin
        r.rd_value    = pc + LINK_STEP;
        r.next_pc     = (rs1 + imm) & ~32'd1;
        r.pc_redirect = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    // an illegal word clears everything but the destination index
    if (bad) begin
      r         = '0;
      r.illegal = 1'b1;
    end else begin
      r.rd_write = 1'b1;
    end
    r.rd_index = insn[11:7];
    return r;
  endfunction

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      report($sformatf("result %0d %s: expected %h, got %h", checked, name, want, got));
  endtask

  // sampled on the falling edge, away from the edge where words move
  always @(negedge clk) begin : watch
    exec_result_t got;
    exec_result_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(execute_itype(kind_t'(in_mon.opcode), in_mon.instr_word,
                                           in_mon.rs1_value, in_mon.pc_value,
                                           in_mon.mem_data));
      if (out_mon.valid && out_mon.ready) begin
        got = '{rd_value: out_mon.rd_value, rd_index: out_mon.rd_index,
                rd_write: out_mon.rd_write, mem_address: out_mon.mem_address,
                mem_size: out_mon.mem_size, next_pc: out_mon.next_pc,
                pc_redirect: out_mon.pc_redirect, illegal: out_mon.illegal};
        if (expected_q.size() == 0) begin
          report("result word with no instruction outstanding");
        end else begin
          want = expected_q.pop_front();
          compare_field("rd_value", want.rd_value, got.rd_value);
          compare_field("rd_index", 32'(want.rd_index), 32'(got.rd_index));
          compare_field("rd_write", 32'(want.rd_write), 32'(got.rd_write));
          compare_field("mem_address", want.mem_address, got.mem_address);
          compare_field("mem_size", 32'(want.mem_size), 32'(got.mem_size));
          compare_field("next_pc", want.next_pc, got.next_pc);
          compare_field("pc_redirect", 32'(want.pc_redirect), 32'(got.pc_redirect));
          compare_field("illegal", 32'(want.illegal), 32'(got.illegal));
          checked++;
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

### tb/rv32i_itype_execute_tb.sv
// ----------------------------------------------------------------------------
// rv32i_itype_execute_tb
// drives i-format instruction words into the execute pipeline, first a
// directed set of corner cases and then a long random stream, with random
// stalls on both channels; the checker beside the block judges every result
// ----------------------------------------------------------------------------
module rv32i_itype_execute_tb import rvie_pkg::*; import rvie_tb_pkg::*;;

  localparam int RANDOM_WORDS = 550;
  // the worst case per word is far below this limit, so it leaves a wide margin
  localparam int CYCLE_LIMIT  = 200000;
  // pipeline is three deep, a few spare cycles catch stray result words
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst_n;

  rvie_in_if  in_bus ();
  rvie_out_if out_bus ();

  int mismatches;
  int pending;
  int checked;
  int cycles = 0;
  int sent_by_kind[4];

  // when set, both sides run flat out with no idle cycles
  logic burst = 1'b0;

  rv32i_itype_execute dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  rv32i_itype_execute_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a hang anywhere ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // i-format word; rs1 field and the major opcode bits are filler the block ignores
  function automatic logic [31:0] itype(logic [11:0] imm12, logic [2:0] f3, logic [4:0] rd);
    return {imm12, 5'($urandom), f3, rd, 7'($urandom)};
  endfunction

  // immediate field of a shift: selector in the top two bits, junk below, amount
  function automatic logic [11:0] shift_imm(logic [1:0] sel, logic [4:0] amount);
    return {sel, 5'($urandom), amount};
  endfunction

  // operand values leaning on the sign and carry corners
  function automatic logic [31:0] edge_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one word on the input channel, with a random idle gap in front of it;
  // returns on the rising edge at which the word is taken
  task automatic send_word(kind_t kind, logic [31:0] insn, logic [31:0] rs1,
                           logic [31:0] pc, logic [31:0] mdata);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= kind;
    in_bus.instr_word <= insn;
    in_bus.rs1_value  <= rs1;
    in_bus.pc_value   <= pc;
    in_bus.mem_data   <= mdata;
    sent_by_kind[kind]++;
    do @(negedge clk); while (!in_bus.ready);
    @(posedge clk);
  endtask

  // hold the sender until every result in flight has come back
  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stall per word, sometimes only once the word is showing
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        if ($urandom_range(0, 1)) begin
          do @(negedge clk); while (!out_bus.valid);
          @(posedge clk);
        end
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(negedge clk); while (!out_bus.valid);
      @(posedge clk);
    end
  end

  initial begin
    kind_t       kind;
    logic [2:0]  f3;
    logic [11:0] imm12;
    logic [1:0]  sel;
    logic [2:0]  load_codes[5];
    load_codes = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};

    // everything known from time zero
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= KIND_ALU;
    in_bus.instr_word <= '0;
    in_bus.rs1_value  <= '0;
    in_bus.pc_value   <= '0;
    in_bus.mem_data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: immediate alu, sign and carry corners of the immediate
    send_word(KIND_ALU, itype(12'h800, F3_ADDI, 5'd0), 32'h0000_0000, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'h7FF, F3_ADDI, 5'd31), 32'h7FFF_F801, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'h000, F3_SLTI, 5'd1), 32'h8000_0000, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'h800, F3_SLTI, 5'd2), 32'h7FFF_FFFF, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'hFFF, F3_SLTIU, 5'd3), 32'h0000_0000, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'hFFF, F3_SLTIU, 5'd4), 32'hFFFF_FFFF, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'hFFF, F3_XORI, 5'd5), 32'hA5A5_A5A5, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'h800, F3_ORI, 5'd6), 32'h0000_0000, $urandom, $urandom);
    send_word(KIND_ALU, itype(12'h7FF, F3_ANDI, 5'd7), 32'hFFFF_FFFF, $urandom, $urandom);
    // left shift ignores the upper immediate bits, so set them all
    send_word(KIND_ALU, itype({7'h7F, 5'd31}, F3_SLLI, 5'd8), 32'h0000_0001,
              $urandom, $urandom);
    send_word(KIND_ALU, itype(shift_imm(SHIFT_LOGICAL, 5'd31), F3_SRXI, 5'd9),
              32'h8000_0000, $urandom, $urandom);
    send_word(KIND_ALU, itype(shift_imm(SHIFT_ARITH, 5'd31), F3_SRXI, 5'd10),
              32'h8000_0000, $urandom, $urandom);
    // right shift with a reserved selector is illegal
    send_word(KIND_ALU, itype(shift_imm(SHIFT_RSVD_LO, 5'd3), F3_SRXI, 5'd11),
              32'h8000_0000, $urandom, $urandom);
    send_word(KIND_ALU, itype(shift_imm(SHIFT_RSVD_HI, 5'd3), F3_SRXI, 5'd12),
              32'h8000_0000, $urandom, $urandom);

    // every load funct3, legal and not, with negative data at each size
    for (int code = 0; code < 8; code++)
      send_word(KIND_LOAD, itype(12'h800, 3'(code), 5'(code + 13)), 32'hFFFF_FFFF,
                $urandom, 32'hFFFF_8080);

    // jalr: link wraps past the top, odd target, funct3 left unchecked
    send_word(KIND_JALR, itype(12'h000, F3_SRXI, 5'd30), 32'h0000_0003, 32'hFFFF_FFFC,
              $urandom);
    send_word(KIND_JALR, itype(12'h800, F3_ADDI, 5'd29), 32'h0000_0000, $urandom, $urandom);
    // reserved instruction class
    send_word(KIND_RSVD, itype(12'h123, F3_ADDI, 5'd28), $urandom, $urandom, $urandom);

    // let the pipeline empty completely before the random stream
    in_bus.valid <= 1'b0;
    wait_drained();

    // random: mostly legal encodings with random operands, some illegal ones
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 40 == 0)
        burst = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_WORDS / 2) begin
        in_bus.valid <= 1'b0;
        wait_drained();
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = KIND_ALU;
        4, 5, 6:    kind = KIND_LOAD;
        7, 8:       kind = KIND_JALR;
        default:    kind = KIND_RSVD;
      endcase
      f3 = 3'($urandom);
      if (kind == KIND_LOAD && $urandom_range(0, 9) != 0)
        f3 = load_codes[$urandom_range(0, 4)];
      case ($urandom_range(0, 7))
        0:       imm12 = 12'h800;
        1:       imm12 = 12'h7FF;
        2:       imm12 = 12'hFFF;
        3:       imm12 = 12'h000;
        default: imm12 = 12'($urandom);
      endcase
      if (kind == KIND_ALU && f3 == F3_SRXI) begin
        if ($urandom_range(0, 9) == 0)
          sel = $urandom_range(0, 1) ? SHIFT_RSVD_LO : SHIFT_RSVD_HI;
        else
          sel = $urandom_range(0, 1) ? SHIFT_LOGICAL : SHIFT_ARITH;
        imm12 = shift_imm(sel, 5'($urandom));
      end
      send_word(kind, itype(imm12, f3, 5'($urandom)), edge_word(), $urandom, edge_word());
    end
    in_bus.valid <= 1'b0;
    burst = 1'b0;

    // wait out the last results, then a few more cycles for anything stray
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d alu, %0d load, %0d jalr and %0d reserved-class words; %0d results checked",
             sent_by_kind[KIND_ALU], sent_by_kind[KIND_LOAD], sent_by_kind[KIND_JALR],
             sent_by_kind[KIND_RSVD], checked);
    $display("directed corners, every funct3 and shift selector, random stalls, %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
src/rvie_pkg.sv
src/rvie_if.sv
src/rvie_decode.sv
src/rv32i_itype_execute.sv
tb/rvie_tb_pkg.sv
tb/rv32i_itype_execute_checker.sv
tb/rv32i_itype_execute_tb.sv
